### rtl/ofsl_pkg.sv
// Shared types and constants for the object file section loader.
// Holds the result item type, result kinds, error codes and section type words.
// No dependencies.
package ofsl_pkg;

    // Result kinds
    localparam logic [1:0] RK_WRITE = 2'd0;
    localparam logic [1:0] RK_ERROR = 2'd1;
    localparam logic [1:0] RK_DONE  = 2'd2;

    // Error codes
    localparam logic [2:0] EC_CODE_HDR  = 3'd0;
    localparam logic [2:0] EC_CODE_WORD = 3'd1;
    localparam logic [2:0] EC_DATA_HDR  = 3'd2;
    localparam logic [2:0] EC_DATA_WORD = 3'd3;
    localparam logic [2:0] EC_SYM_HDR   = 3'd4;
    localparam logic [2:0] EC_FILE_HDR  = 3'd5;
    localparam logic [2:0] EC_LINE_HDR  = 3'd6;
    localparam logic [2:0] EC_UNKNOWN   = 3'd7;

    // Section type words
    localparam logic [15:0] TYPE_CODE = 16'hCADE;
    localparam logic [15:0] TYPE_DATA = 16'hDADA;
    localparam logic [15:0] TYPE_SYM  = 16'hC3B7;
    localparam logic [15:0] TYPE_FILE = 16'hF17E;
    localparam logic [15:0] TYPE_LINE = 16'h715E;

    // Mask that keeps the low byte of a word
    localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [15:0] word;
        logic [2:0]  code;
    } t_result;

endpackage

### rtl/object_file_section_loader.sv
// Top level of the object file section loader: parser state plus result buffer.
// Instantiates ofsl_parser and ofsl_out_buf; depends on ofsl_pkg.
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_data_byte, i_end_of_file
// result    out        o_out_valid / i_out_ready    o_result_kind, o_write_address,
//                                                   o_write_word, o_error_code
//
// One item per cycle while o_in_ready is high: each byte updates the parser state in the
// cycle it is accepted, and its result, if any, is registered in the result register or,
// under output stall, in the skid stage. This two-entry buffer lets input go on during a
// stall until the skid stage fills; o_in_ready drops only while the skid stage is full.
// Synchronous active-low reset returns the parser to awaiting a section type.
// After a finish or an error, items are still accepted but produce no results.
module object_file_section_loader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_write_address,
    output logic [15:0] o_write_word,
    output logic [2:0]  o_error_code
);
    import ofsl_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign w_accept = i_in_valid && o_in_ready;

    // Parser state and result forming
    ofsl_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // Result register and skid stage
    ofsl_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_res_valid),
        .i_res        (w_res),
        .o_can_accept (o_in_ready),
        .o_valid      (o_out_valid),
        .i_take       (i_out_ready),
        .o_res        (w_out)
    );

    assign o_result_kind   = w_out.kind;
    assign o_write_address = w_out.address;
    assign o_write_word    = w_out.word;
    assign o_error_code    = w_out.code;

endmodule

### rtl/ofsl_parser.sv
// Byte-level parser state for the object file section loader.
// Updates the parse state on every accepted item until it finishes or fails, and forms at most one result.
// Depends on ofsl_pkg.
module ofsl_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_file,
    output logic              o_res_valid,
    output ofsl_pkg::t_result o_res
);
    import ofsl_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        SK_CODE,
        SK_DATA,
        SK_SYM,
        SK_FILE,
        SK_LINE
    } t_kind;

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_high, n_high;
    logic        r_parity, n_parity;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_count, n_count;
    logic [15:0] r_index, n_index;
    logic [1:0]  r_hidx, n_hidx;

    logic [15:0] w_word;
    logic [15:0] w_index_inc;
    logic [2:0]  w_hdr_code;

    assign w_word      = ({r_high, 8'h00}) | ({8'h00, i_data_byte} & LOW_BYTE_MASK);
    assign w_index_inc = r_index + 16'd1;

    // Error code for an end marker that lands inside a header
    always_comb begin
        case (r_kind)
            SK_CODE: w_hdr_code = EC_CODE_HDR;
            SK_DATA: w_hdr_code = EC_DATA_HDR;
            SK_SYM:  w_hdr_code = EC_SYM_HDR;
            SK_FILE: w_hdr_code = EC_FILE_HDR;
            default: w_hdr_code = EC_LINE_HDR;
        endcase
    end

    // Next state and result for the item being accepted
    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_high      = r_high;
        n_parity    = r_parity;
        n_addr      = r_addr;
        n_count     = r_count;
        n_index     = r_index;
        n_hidx      = r_hidx;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept && (r_phase != PH_DONE)) begin
            if (i_end_of_file) begin
                n_phase     = PH_DONE;
                o_res_valid = 1'b1;
                if (r_phase == PH_HEADER) begin
                    o_res.kind = RK_ERROR;
                    o_res.code = w_hdr_code;
                end else if (r_phase == PH_PAYLOAD) begin
                    o_res.kind = RK_ERROR;
                    o_res.code = (r_kind == SK_CODE) ? EC_CODE_WORD : EC_DATA_WORD;
                end else begin
                    o_res.kind = RK_DONE;
                end
            end else if (r_phase == PH_SKIP) begin
                n_index = w_index_inc;
                if (w_index_inc == r_count) begin
                    n_phase = PH_TYPE;
                end
            end else if (!r_parity) begin
                n_high   = i_data_byte;
                n_parity = 1'b1;
            end else begin
                n_parity = 1'b0;
                case (r_phase)
                    PH_TYPE: begin
                        n_hidx  = 2'd0;
                        n_phase = PH_HEADER;
                        if (w_word == TYPE_CODE) begin
                            n_kind = SK_CODE;
                        end else if (w_word == TYPE_DATA) begin
                            n_kind = SK_DATA;
                        end else if (w_word == TYPE_SYM) begin
                            n_kind = SK_SYM;
                        end else if (w_word == TYPE_FILE) begin
                            n_kind = SK_FILE;
                        end else if (w_word == TYPE_LINE) begin
                            n_kind = SK_LINE;
                        end else begin
                            n_phase     = PH_DONE;
                            o_res_valid = 1'b1;
                            o_res.kind  = RK_ERROR;
                            o_res.code  = EC_UNKNOWN;
                        end
                    end
                    PH_HEADER: begin
                        if (r_kind == SK_LINE) begin
                            if (r_hidx >= 2'd2) begin
                                n_phase = PH_TYPE;
                            end else begin
                                n_hidx = r_hidx + 2'd1;
                            end
                        end else if ((r_kind != SK_FILE) && (r_hidx == 2'd0)) begin
                            n_addr = w_word;
                            n_hidx = 2'd1;
                        end else begin
                            // Count word closes the header and opens the body, or ends the section when it is zero.
                            n_count = w_word;
                            n_index = 16'd0;
                            if (w_word == 16'd0) begin
                                n_phase = PH_TYPE;
                            end else if ((r_kind == SK_CODE) || (r_kind == SK_DATA)) begin
                                n_phase = PH_PAYLOAD;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_index       = w_index_inc;
                        o_res_valid   = 1'b1;
                        o_res.kind    = RK_WRITE;
                        o_res.address = r_addr + r_index;
                        o_res.word    = w_word;
                        if (w_index_inc == r_count) begin
                            n_phase = PH_TYPE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_kind   <= SK_CODE;
            r_high   <= 8'd0;
            r_parity <= 1'b0;
            r_addr   <= 16'd0;
            r_count  <= 16'd0;
            r_index  <= 16'd0;
            r_hidx   <= 2'd0;
        end else begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_high   <= n_high;
            r_parity <= n_parity;
            r_addr   <= n_addr;
            r_count  <= n_count;
            r_index  <= n_index;
            r_hidx   <= n_hidx;
        end
    end

    // Once finished or failed, the parser never leaves the done phase.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("parser left the done phase");

    // A finished parser produces no further results.
    a_no_result_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> !o_res_valid)
        else $error("result produced after finish");

    // Every error or finish result moves the parser into the done phase.
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind != RK_WRITE)) |=> (r_phase == PH_DONE))
        else $error("final result without entering done phase");

    // Writes only come from a payload word, never with the end marker.
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == RK_WRITE)) |-> (r_phase == PH_PAYLOAD && !i_end_of_file))
        else $error("write outside payload");

endmodule

### rtl/ofsl_out_buf.sv
// Result register with a skid stage for the object file section loader.
// Lets the input side accept an item while a finished result still waits.
// Depends on ofsl_pkg.
module ofsl_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ofsl_pkg::t_result i_res,
    output logic              o_can_accept,
    output logic              o_valid,
    input  logic              i_take,
    output ofsl_pkg::t_result o_res
);
    import ofsl_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_move;

    assign o_can_accept = !r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_res        = r_out;
    assign w_move       = !r_out_valid || i_take;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    // The skid stage only fills behind a held result.
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item with an empty output register");

    // No push arrives while the skid stage is full.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into a full buffer");

    // A stalled output with a new result parks it in the skid stage.
    a_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_take && i_push) |=> r_skid_valid)
        else $error("stalled result lost");

    // Draining the skid stage refills the output register.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_take) |=> (r_out_valid && !r_skid_valid))
        else $error("skid drain failed");

endmodule
